@@ src/mod_prime_arithmetic_unit_defines.svh @@
// Assertion macros for the modular arithmetic unit
`ifndef MOD_PRIME_ARITHMETIC_UNIT_DEFINES_SVH
`define MOD_PRIME_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MPAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MPAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mpau_pkg.sv @@
// Shared types and constants of the modular arithmetic unit
package mpau_pkg;

  localparam logic [1:0] FUNC_MUL = 2'd0;
  localparam logic [1:0] FUNC_ROW = 2'd1;
  localparam logic [1:0] FUNC_INV = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [63:0] PRIME_RESET = 64'd32003;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RED  = 8'b00000010,
    S_MUL  = 8'b00000100,
    S_ADD  = 8'b00001000,
    S_DIV  = 8'b00010000,
    S_UPD  = 8'b00100000,
    S_FIX  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

endpackage

@@ src/mod_prime_arithmetic_unit.sv @@
// Bit-serial modular multiply, row update and inverse over Z/pZ
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_data (modulus p)
//  in      | in  | in_valid / in_ready    | func, operand_x, scale_a, operand_y
//  out     | out | out_valid / out_ready  | result_value
//
// One request at a time. Operand reduction runs three remainder lanes, one
// dividend bit per cycle. Multiply then doubles, then conditionally adds,
// per multiplier bit; row update adds x in a final add step. Inverse runs
// extended Euclid: each quotient step is a bit-serial division, at most
// about 1.45*MOD_WIDTH steps.
// Reset (rst, synchronous) loads modulus 32003 and empties the output register.
// A new request is taken while a finished result waits in the output register.
`include "mod_prime_arithmetic_unit_defines.svh"

module mod_prime_arithmetic_unit #(
  parameter int MOD_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [MOD_WIDTH-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [MOD_WIDTH-1:0] operand_x,
  input  logic [MOD_WIDTH-1:0] scale_a,
  input  logic [MOD_WIDTH-1:0] operand_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MOD_WIDTH-1:0] result_value
);

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(MOD_WIDTH + 1);

  mpau_pkg::state_t state;
  logic [CW-1:0]    cnt;
  logic             phase;
  logic [W-1:0]     prime;
  logic [1:0]       op;

  logic [W-1:0] lsh [3];
  logic [W-1:0] lrem [3];
  logic [W-1:0] lrem_next [3];

  logic [W-1:0] mu, ysh, acc, res;
  logic [W-1:0] r0, r1, rem, dvd;
  logic signed [W+1:0] t0, t1, qt;

  // Modular adder shared by multiply and row update
  logic [W-1:0] addend;
  logic [W:0]   msum, msub;
  logic [W-1:0] msum_red;

  // Division step
  logic [W:0]   drem2, dsub;
  logic         dge;
  logic [W-1:0] drem_next;
  logic signed [W+1:0] qt_next, tfix;

  logic accept;
  logic last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == mpau_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign last      = (cnt == CW'(1));

  // Remainder lanes for x, a, y: one dividend bit per cycle
  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [W:0] rr2, rsub;
    assign rr2  = {lrem[g], lsh[g][W-1]};
    assign rsub = rr2 - {1'b0, prime};
    assign lrem_next[g] = (rr2 >= {1'b0, prime}) ? rsub[W-1:0] : rr2[W-1:0];
  end

  // Pick addend: doubling, conditional multiplicand, or final x
  always_comb begin
    if (state == mpau_pkg::S_ADD) begin
      addend = lrem[0];
    end else if (!phase) begin
      addend = acc;
    end else begin
      addend = ysh[W-1] ? mu : '0;
    end
    msum     = {1'b0, acc} + {1'b0, addend};
    msub     = msum - {1'b0, prime};
    msum_red = (msum >= {1'b0, prime}) ? msub[W-1:0] : msum[W-1:0];
  end

  // Restoring division of r0 by r1, quotient folded into q*t1
  always_comb begin
    drem2     = {rem, dvd[W-1]};
    dsub      = drem2 - {1'b0, r1};
    dge       = (drem2 >= {1'b0, r1});
    drem_next = dge ? dsub[W-1:0] : drem2[W-1:0];
    qt_next   = (qt <<< 1) + (dge ? t1 : '0);
    tfix      = t0[W+1] ? (t0 + $signed({2'b00, prime})) : t0;
  end

  // Control: sequencer, counters, modulus register, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mpau_pkg::S_IDLE;
      cnt       <= '0;
      phase     <= 1'b0;
      prime     <= W'(mpau_pkg::PRIME_RESET);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        prime <= cfg_data;
      end
      // Raise valid on hand-off from done, drop it once taken
      if (state == mpau_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mpau_pkg::S_IDLE: begin
          if (accept) begin
            cnt <= CW'(W);
            if (prime == '0 || func == mpau_pkg::FUNC_NONE) begin
              state <= mpau_pkg::S_DONE;
            end else begin
              state <= mpau_pkg::S_RED;
            end
          end
        end
        mpau_pkg::S_RED: begin
          if (last) begin
            cnt <= CW'(W);
            if (op == mpau_pkg::FUNC_INV) begin
              state <= (lrem_next[0] == '0) ? mpau_pkg::S_FIX : mpau_pkg::S_DIV;
            end else begin
              phase <= 1'b0;
              state <= mpau_pkg::S_MUL;
            end
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        mpau_pkg::S_MUL: begin
          phase <= !phase;
          if (phase) begin
            cnt <= cnt - CW'(1);
            if (last) begin
              state <= (op == mpau_pkg::FUNC_ROW) ? mpau_pkg::S_ADD : mpau_pkg::S_DONE;
            end
          end
        end
        mpau_pkg::S_ADD: begin
          state <= mpau_pkg::S_DONE;
        end
        mpau_pkg::S_DIV: begin
          cnt <= cnt - CW'(1);
          if (last) begin
            state <= mpau_pkg::S_UPD;
          end
        end
        mpau_pkg::S_UPD: begin
          cnt   <= CW'(W);
          state <= (rem == '0) ? mpau_pkg::S_FIX : mpau_pkg::S_DIV;
        end
        mpau_pkg::S_FIX: begin
          state <= mpau_pkg::S_DONE;
        end
        mpau_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= mpau_pkg::S_IDLE;
          end
        end
        default: begin
          state <= mpau_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      mpau_pkg::S_IDLE: begin
        if (accept) begin
          op     <= func;
          lsh[0] <= operand_x;
          lsh[1] <= scale_a;
          lsh[2] <= operand_y;
          for (int i = 0; i < 3; i++) begin
            lrem[i] <= '0;
          end
          res <= '0;
        end
      end
      mpau_pkg::S_RED: begin
        for (int i = 0; i < 3; i++) begin
          lrem[i] <= lrem_next[i];
          lsh[i]  <= lsh[i] << 1;
        end
        if (last) begin
          mu  <= (op == mpau_pkg::FUNC_ROW) ? lrem_next[1] : lrem_next[0];
          ysh <= lrem_next[2];
          acc <= '0;
          r0  <= prime;
          r1  <= lrem_next[0];
          dvd <= prime;
          rem <= '0;
          qt  <= '0;
          t0  <= '0;
          t1  <= (prime > W'(1)) ? (W+2)'(1) : '0;
        end
      end
      mpau_pkg::S_MUL: begin
        acc <= msum_red;
        if (phase) begin
          ysh <= ysh << 1;
          res <= msum_red;
        end
      end
      mpau_pkg::S_ADD: begin
        res <= msum_red;
      end
      mpau_pkg::S_DIV: begin
        rem <= drem_next;
        dvd <= dvd << 1;
        qt  <= qt_next;
      end
      mpau_pkg::S_UPD: begin
        r0  <= r1;
        r1  <= rem;
        t0  <= t1;
        t1  <= t0 - qt;
        dvd <= r1;
        rem <= '0;
        qt  <= '0;
      end
      mpau_pkg::S_FIX: begin
        res <= (r0 == W'(1)) ? tfix[W-1:0] : '0;
      end
      mpau_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          result_value <= res;
        end
      end
      default: begin
        res <= '0;
      end
    endcase
  end

  `MPAU_ASSERT_NXT(a_accept_busy, accept, state != mpau_pkg::S_IDLE, "request accepted but idle")
  `MPAU_ASSERT_NXT(a_fix_done, state == mpau_pkg::S_FIX, state == mpau_pkg::S_DONE, "fix not done")
  `MPAU_ASSERT_IMP(a_res_range, state == mpau_pkg::S_DONE && prime != '0 && op != mpau_pkg::FUNC_NONE, res < prime, "result not reduced")
  `MPAU_ASSERT_IMP(a_red_range, state == mpau_pkg::S_RED && cnt != CW'(W), lrem[0] < prime, "remainder not below modulus")
  `MPAU_ASSERT_IMP(a_div_order, state == mpau_pkg::S_DIV, r1 < r0 && r1 != '0, "divisor out of order")

endmodule

@@ tb/tb_top.sv @@
// Testbench for the modular arithmetic unit: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int W = 31;
  localparam int WATCHDOG_LIMIT = 60000;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [W-1:0] cfg_data;
  logic         in_valid;
  logic         in_ready;
  logic [1:0]   func;
  logic [W-1:0] operand_x;
  logic [W-1:0] scale_a;
  logic [W-1:0] operand_y;
  logic         out_valid;
  logic         out_ready;
  logic [W-1:0] result_value;

  // Modulus as currently held by the unit, and results still owed by it
  logic [W-1:0] cur_modulus;
  logic [W-1:0] pending_results[$];
  int           errors;
  int           idle_cycles;
  bit           quiet;
  int           out_stall;

  mod_prime_arithmetic_unit #(.MOD_WIDTH(W)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .operand_x(operand_x), .scale_a(scale_a), .operand_y(operand_y),
    .out_valid(out_valid), .out_ready(out_ready), .result_value(result_value)
  );

  always #10 clk = ~clk;

  // Inverse by extended Euclid; 0 when no inverse exists
  function automatic logic [W-1:0] euclid_inverse(logic [63:0] u, logic [63:0] m);
    longint r0, r1, t0, t1, q, tmp;
    r0 = m;
    r1 = u;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = t0 - q * t1;
      t0 = t1;
      t1 = tmp;
    end
    if (r0 != 1) return '0;
    t0 = t0 % longint'(m);
    if (t0 < 0) t0 = t0 + longint'(m);
    return t0[W-1:0];
  endfunction

  function automatic logic [W-1:0] modular_result(logic [1:0] f, logic [W-1:0] xi,
                                                  logic [W-1:0] ai, logic [W-1:0] yi,
                                                  logic [W-1:0] p);
    logic [63:0] m, x, a, y, r;
    m = 64'(p);
    if (m == 0) return '0;
    x = 64'(xi) % m;
    a = 64'(ai) % m;
    y = 64'(yi) % m;
    case (f)
      mpau_pkg::FUNC_MUL: r = (x * y) % m;
      mpau_pkg::FUNC_ROW: r = (x + (a * y) % m) % m;
      mpau_pkg::FUNC_INV: r = 64'(euclid_inverse(x, m));
      default:            r = 0;
    endcase
    return r[W-1:0];
  endfunction

  // Check each result against the oldest prediction; watch for a hang
  always @(posedge clk) begin
    logic [W-1:0] want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, result_value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (result_value !== want) begin
            $display("%0t: result_value mismatch, expected %0d, actual %0d",
                     $time, want, result_value);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stall the result side in short bursts
  always @(negedge clk) begin
    if (quiet || rst) begin
      out_ready = 1'b1;
      out_stall = 0;
    end else if (out_stall > 0) begin
      out_ready = 1'b0;
      out_stall--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      out_stall = $urandom_range(0, 2);
    end else begin
      out_ready = 1'b1;
    end
  end

  // Drive one request and record its prediction on acceptance
  task automatic send_request(logic [1:0] f, logic [W-1:0] x, logic [W-1:0] a,
                              logic [W-1:0] y);
    if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) @(negedge clk);
    in_valid = 1'b1;
    func = f;
    operand_x = x;
    scale_a = a;
    operand_y = y;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(modular_result(f, x, a, y, cur_modulus));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Load a new modulus while the unit is idle
  task automatic set_modulus(logic [W-1:0] p);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data = p;
    do @(posedge clk); while (!cfg_ready);
    cur_modulus = p;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_reset_modulus();
    logic [W-1:0] pm1;
    pm1 = W'(mpau_pkg::PRIME_RESET) - W'(1);
    send_request(mpau_pkg::FUNC_MUL, W'(0), W'(0), W'(0));
    send_request(mpau_pkg::FUNC_MUL, pm1, W'(0), pm1);
    send_request(mpau_pkg::FUNC_MUL, pm1, W'(0), W'(0));
    send_request(mpau_pkg::FUNC_ROW, W'(5), W'(1), W'(77));
    send_request(mpau_pkg::FUNC_ROW, pm1, pm1, pm1);
    send_request(mpau_pkg::FUNC_ROW, W'(9), W'(0), W'(123));
    send_request(mpau_pkg::FUNC_INV, W'(0), W'(0), W'(0));
    send_request(mpau_pkg::FUNC_INV, W'(1), W'(0), W'(0));
    send_request(mpau_pkg::FUNC_INV, pm1, W'(0), W'(0));
    send_request(mpau_pkg::FUNC_NONE, '1, '1, '1);
    send_request(mpau_pkg::FUNC_MUL, '1, '1, '1);
  endtask

  task automatic test_extreme_moduli();
    set_modulus(W'(2147483647));
    send_request(mpau_pkg::FUNC_MUL, W'(2147483646), W'(0), W'(2147483646));
    send_request(mpau_pkg::FUNC_ROW, W'(2147483646), W'(2147483646), W'(2147483646));
    send_request(mpau_pkg::FUNC_INV, W'(2147483646), W'(0), W'(0));
    send_request(mpau_pkg::FUNC_INV, '1, W'(0), W'(0));
    set_modulus(W'(3));
    send_request(mpau_pkg::FUNC_ROW, W'(2), W'(2), W'(2));
    send_request(mpau_pkg::FUNC_INV, W'(2), W'(0), W'(0));
    set_modulus(W'(1));
    send_request(mpau_pkg::FUNC_ROW, W'(1), W'(1), W'(1));
    send_request(mpau_pkg::FUNC_INV, W'(5), W'(0), W'(0));
    set_modulus(W'(0));
    send_request(mpau_pkg::FUNC_MUL, W'(7), W'(3), W'(9));
    send_request(mpau_pkg::FUNC_INV, W'(7), W'(0), W'(0));
    set_modulus(W'(91));
    send_request(mpau_pkg::FUNC_INV, W'(7), W'(0), W'(0));
    send_request(mpau_pkg::FUNC_INV, W'(8), W'(0), W'(0));
    set_modulus(W'(1000000));
    send_request(mpau_pkg::FUNC_MUL, W'(999999), W'(0), W'(999999));
  endtask

  task automatic test_random_traffic();
    logic [W-1:0] primes[10];
    logic [W-1:0] p, x, a, y;
    logic [1:0]   f;
    primes = '{3, 5, 7, 251, 32003, 65521, 1000003, 2147483629, 2147483647, 1073741789};
    for (int phase = 0; phase < 15; phase++) begin
      if (phase >= 12) quiet = 1'b1;
      case ($urandom_range(0, 5))
        0:       p = W'($urandom);
        1:       p = W'($urandom_range(0, 300));
        default: p = primes[$urandom_range(0, 9)];
      endcase
      set_modulus(p);
      for (int i = 0; i < 122; i++) begin
        f = $urandom_range(0, 9) == 0 ? 2'($urandom) : 2'($urandom_range(0, 2));
        if (p > 1 && $urandom_range(0, 7) != 0) begin
          x = W'($urandom_range(0, p - 1));
          a = $urandom_range(0, 3) == 0 ? (p - W'(1)) : W'($urandom_range(0, p - 1));
          y = W'($urandom_range(0, p - 1));
        end else begin
          x = W'($urandom);
          a = W'($urandom);
          y = W'($urandom);
        end
        send_request(f, x, a, y);
        // hold the sender until all results are back
        if (phase == 5 && i == 60) wait_drained();
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = mpau_pkg::FUNC_MUL;
    operand_x = '0;
    scale_a = '0;
    operand_y = '0;
    out_ready = 1'b1;
    out_stall = 0;
    quiet = 1'b0;
    errors = 0;
    idle_cycles = 0;
    cur_modulus = W'(mpau_pkg::PRIME_RESET);
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_reset_modulus();
    test_extreme_moduli();
    test_random_traffic();

    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/mpau_pkg.sv
src/mod_prime_arithmetic_unit.sv
tb/tb_top.sv
